// ===== src/assert_macros.svh =====
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CVPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cvpg assertion failed");

// next-cycle implication
`define CVPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cvpg assertion failed");

`endif

// ===== src/cvpg_pkg.sv =====
package cvpg_pkg;

	localparam int MAX_TRIALS_DEF = 200;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int COEF_W = 40;
	// shared multiply / divide unit
	localparam int ALU_NW = 80;
	localparam int ALU_DW = 42;
	localparam int ALU_RW = 2 * ALU_DW;
	localparam int ALU_CW = $clog2(ALU_NW + 1);
	localparam logic [ALU_CW-1:0] MUL_STEPS = ALU_CW'(ALU_DW);
	localparam logic [ALU_CW-1:0] DIV_STEPS = ALU_CW'(ALU_NW);

	localparam logic [15:0] RST_INITIAL_DURATION = 16'd1000;
	localparam logic [7:0]  RST_TICK_PERIOD      = 8'd5;
	localparam logic [11:0] RST_SPEED_LIMIT      = 12'd1000;

	typedef enum logic [2:0] {
		CFG_START_SPEED,
		CFG_END_SPEED,
		CFG_MOVE_DISTANCE,
		CFG_INITIAL_DURATION,
		CFG_TICK_PERIOD,
		CFG_SPEED_LIMIT
	} cfg_idx_t;

	typedef enum logic {
		CMD_PLAN,
		CMD_SAMPLE
	} cmd_t;

	typedef struct packed {
		logic [11:0] start_speed;
		logic [11:0] end_speed;
		logic [15:0] move_distance;
		logic [15:0] initial_duration;
		logic [7:0]  tick_period;
		logic [11:0] speed_limit;
	} cfg_regs_t;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [ALU_NW-1:0] a;
		logic [ALU_DW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [ALU_RW-1:0] result;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FIT,
		ST_FIT_WAIT,
		ST_PEAK,
		ST_SQ_WAIT,
		ST_PDIV_WAIT,
		ST_TRIAL_END,
		ST_CHECK,
		ST_CNT,
		ST_CNT_WAIT,
		ST_UDIV,
		ST_UDIV_WAIT,
		ST_U2,
		ST_U2_WAIT,
		ST_T2_WAIT,
		ST_T3_WAIT,
		ST_DONE
	} cvpg_state_t;

endpackage

// ===== src/cvpg_if.sv =====
interface cvpg_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        tune_duration;
	logic [15:0] sample_index;

	modport source (output valid, cmd, tune_duration, sample_index, input ready);
	modport sink (input valid, cmd, tune_duration, sample_index, output ready);
endinterface

interface cvpg_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] speed;
	logic [15:0] sample_count;
	logic [15:0] planned_duration;
	logic        is_last;
	logic        index_bad;

	modport source (output valid, speed, sample_count, planned_duration, is_last, index_bad,
		input ready);
	modport sink (input valid, speed, sample_count, planned_duration, is_last, index_bad,
		output ready);
endinterface

interface cvpg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cvpg_cfg_regs.sv =====
module cvpg_cfg_regs import cvpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cvpg_cfg_if.sink  cfg,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_speed      <= '0;
			regs_q.end_speed        <= '0;
			regs_q.move_distance    <= '0;
			regs_q.initial_duration <= RST_INITIAL_DURATION;
			regs_q.tick_period      <= RST_TICK_PERIOD;
			regs_q.speed_limit      <= RST_SPEED_LIMIT;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_START_SPEED:      regs_q.start_speed      <= cfg.data[11:0];
				CFG_END_SPEED:        regs_q.end_speed        <= cfg.data[11:0];
				CFG_MOVE_DISTANCE:    regs_q.move_distance    <= cfg.data;
				CFG_INITIAL_DURATION: regs_q.initial_duration <= cfg.data;
				CFG_TICK_PERIOD:      regs_q.tick_period      <= cfg.data[7:0];
				CFG_SPEED_LIMIT:      regs_q.speed_limit      <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/cvpg_alu.sv =====
module cvpg_alu import cvpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	alu_op_t           op_q;
	logic              busy_q;
	logic              done_q;
	logic [ALU_CW-1:0] cnt_q;
	logic [ALU_DW-1:0] dv_q;
	logic [ALU_DW-1:0] hi_q;
	logic [ALU_NW-1:0] lo_q;

	logic [ALU_DW:0]   mul_sum;
	logic [ALU_DW:0]   div_trial;
	logic [ALU_DW:0]   div_diff;
	logic              div_ge;
	logic              last_step;

	// one multiplier bit or one quotient bit per cycle
	assign mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, dv_q} : '0);
	assign div_trial = {hi_q, lo_q[ALU_NW-1]};
	assign div_ge    = div_trial >= {1'b0, dv_q};
	assign div_diff  = div_trial - {1'b0, dv_q};
	assign last_step = cnt_q == ((op_q == ALU_MUL) ? MUL_STEPS - 1'b1 : DIV_STEPS - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= ALU_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= '0;
			if (req.op == ALU_MUL) begin
				dv_q <= req.a[ALU_DW-1:0];
				lo_q <= ALU_NW'(req.b);
			end else begin
				dv_q <= req.b;
				lo_q <= req.a;
			end
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				hi_q <= mul_sum[ALU_DW:1];
				lo_q <= {lo_q[ALU_NW-1:ALU_DW], mul_sum[0], lo_q[ALU_DW-1:1]};
			end else begin
				hi_q <= div_ge ? div_diff[ALU_DW-1:0] : div_trial[ALU_DW-1:0];
				lo_q <= {lo_q[ALU_NW-2:0], div_ge};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == ALU_MUL) ? {hi_q, lo_q[ALU_DW-1:0]} : ALU_RW'(lo_q);

endmodule

// ===== src/cubic_velocity_profile_generator.sv =====
// cubic velocity profile generator: a plan request (cmd 0) fits the cubic speed curve
// v(u) = c1 + c2*u + c3*u^2 over normalized time u for the configured start speed, end
// speed and distance, optionally tunes the duration in 10 ms steps until the curve's
// extremum sits within 98..100 percent of speed_limit, and returns the sample count
// ceil(T/tick)+1 and the duration; a sample request (cmd 1) returns the speed at a
// tick index, with the last index taken at the full duration and out-of-range indexes
// flagged. All multiplies and divides run through one shared radix-2 unit that
// resolves one bit per cycle. Each tuning trial runs a fit divide, a squaring and an
// extremum divide, for up to MAX_TRIALS+1 trials. A sample runs a time divide plus
// three multiplies; the last sample skips the divide and a bad index uses no unit at
// all. One request is worked at a time; a finished response waits in an output
// register while the next request is taken. Configuration is written through its own
// channel, which is always ready; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module cubic_velocity_profile_generator import cvpg_pkg::*; #(
	parameter int MAX_TRIALS = MAX_TRIALS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cvpg_req_if.sink   req,
	cvpg_rsp_if.source rsp,
	cvpg_cfg_if.sink   cfg
);

	localparam int UW = FRAC_BITS + 1;
	localparam int TW = $clog2(MAX_TRIALS + 1);
	localparam logic [UW-1:0]            U_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [62:0]              PEAK_CAP = 63'(1) << 62;
	localparam logic signed [63:0]       CMP_CAP  = 64'sd1 <<< 50;
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [55:0] x);
		if (x > 56'(COEF_MAX))
			return COEF_MAX;
		else if (x < 56'(COEF_MIN))
			return COEF_MIN;
		else
			return x[COEF_W-1:0];
	endfunction

	cfg_regs_t   regs;
	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	cvpg_state_t state_q, state_d;

	// planned state
	logic [15:0]              plan_dur_q;
	logic [11:0]              v0_q;
	logic signed [COEF_W-1:0] c2_q, c3_q;
	logic [15:0]              count_q;
	logic                     loop_q;

	// per-request work registers
	logic                     tune_q;
	logic [15:0]              idx_q;
	logic signed [63:0]       peak_q;
	logic [TW-1:0]            trial_q;
	logic [UW-1:0]            u_q, u2_q;
	logic signed [47:0]       t2_q;
	logic [15:0]              spd_q;
	logic                     last_q, bad_q;

	// output register
	logic                     rsp_valid_q;
	logic [15:0]              rsp_speed_q, rsp_count_q, rsp_dur_q;
	logic                     rsp_last_q, rsp_bad_q;
	logic                     load_rsp;

	logic [7:0]               tick;
	logic [15:0]              init_dur;
	logic [28:0]              dist6000;
	logic [ALU_NW-1:0]        q_num;
	logic [55:0]              q_val;
	logic [14:0]              lin_sum, cub_sum;
	logic [12:0]              v_sum;
	logic signed [55:0]       c2_wide, c3_wide;
	logic signed [63:0]       c1;
	logic [COEF_W-1:0]        c2_mag, c3_mag;
	logic [62:0]              m_val;
	logic signed [63:0]       peak_new;
	logic signed [59:0]       pc, pc100, lim, lim98;
	logic                     low, in_win;
	logic [15:0]              dur_adj;
	logic [ALU_NW-1:0]        cnt_num;
	logic [17:0]              n_val;
	logic [15:0]              count_new;
	logic [23:0]              idx_tick;
	logic [ALU_NW-1:0]        u_num;
	logic [UW-1:0]            u_new, u2_new;
	logic [47:0]              t_mag;
	logic signed [47:0]       t2_new, t3_new;
	logic signed [63:0]       sum, s_shift;
	logic [15:0]              speed_new;
	logic                     idx_bad, idx_last;

	cvpg_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cvpg_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// zero tick or duration act as one
	assign tick     = (regs.tick_period == 8'd0) ? 8'd1 : regs.tick_period;
	assign init_dur = (regs.initial_duration == 16'd0) ? 16'd1 : regs.initial_duration;

	// fit: q = 6000*D/T in fixed point, then the two free coefficients
	assign dist6000 = 29'(regs.move_distance) * 29'd6000;
	assign q_num    = ALU_NW'(dist6000) << FRAC_BITS;
	assign q_val    = alu_rsp.result[55:0];
	assign lin_sum  = 15'({regs.start_speed, 2'b00}) + 15'({regs.end_speed, 1'b0});
	assign v_sum    = 13'(regs.start_speed) + 13'(regs.end_speed);
	assign cub_sum  = 15'({v_sum, 1'b0}) + 15'(v_sum);
	assign c2_wide  = $signed(q_val) - ($signed(56'(lin_sum)) <<< FRAC_BITS);
	assign c3_wide  = ($signed(56'(cub_sum)) <<< FRAC_BITS) - $signed(q_val);

	assign c1     = $signed(64'(v0_q)) <<< FRAC_BITS;
	assign c2_mag = c2_q[COEF_W-1] ? COEF_W'(-c2_q) : COEF_W'(c2_q);
	assign c3_mag = c3_q[COEF_W-1] ? COEF_W'(-c3_q) : COEF_W'(c3_q);

	// extremum c1 -/+ c2^2/(4|c3|), quotient capped
	assign m_val    = (|alu_rsp.result[ALU_RW-1:62]) ? PEAK_CAP : alu_rsp.result[62:0];
	assign peak_new = (c3_q > 0) ? c1 - $signed(64'(m_val)) : c1 + $signed(64'(m_val));

	// window test against 98..100 percent of the limit
	always_comb begin
		if (peak_q > CMP_CAP)
			pc = 60'(CMP_CAP);
		else if (peak_q < -CMP_CAP)
			pc = 60'(-CMP_CAP);
		else
			pc = 60'(peak_q);
	end
	assign pc100  = pc * 60'sd100;
	assign lim    = $signed(60'(regs.speed_limit)) <<< FRAC_BITS;
	assign lim98  = lim * 60'sd98;
	assign low    = pc100 <= lim98;
	assign in_win = (pc100 >= lim98) && (pc <= lim);

	// peak too low shortens the move, too high stretches it
	always_comb begin
		if (low)
			dur_adj = (plan_dur_q > 16'd11) ? plan_dur_q - 16'd10 : 16'd1;
		else
			dur_adj = (plan_dur_q < 16'd65525) ? plan_dur_q + 16'd10 : 16'hFFFF;
	end

	// sample count ceil(T/tick)+1, saturated
	assign cnt_num   = ALU_NW'(17'(plan_dur_q) + 17'(tick) - 17'd1);
	assign n_val     = 18'(alu_rsp.result[16:0]) + 18'd1;
	assign count_new = (n_val > 18'd65535) ? 16'hFFFF : n_val[15:0];

	// sample evaluation
	assign idx_bad  = req.sample_index >= count_q;
	assign idx_last = req.sample_index == count_q - 16'd1;
	assign idx_tick = 24'(idx_q) * 24'(tick);
	assign u_num    = ALU_NW'(idx_tick) << FRAC_BITS;
	assign u_new    = (alu_rsp.result > ALU_RW'(U_ONE)) ? U_ONE : alu_rsp.result[UW-1:0];
	assign u2_new   = alu_rsp.result[FRAC_BITS +: UW];
	// products are dropped toward zero, so scale the magnitude then restore the sign
	assign t_mag    = alu_rsp.result[FRAC_BITS +: 48];
	assign t2_new   = c2_q[COEF_W-1] ? -$signed(t_mag) : $signed(t_mag);
	assign t3_new   = c3_q[COEF_W-1] ? -$signed(t_mag) : $signed(t_mag);
	assign sum      = c1 + 64'(t2_q) + 64'(t3_new);
	assign s_shift  = sum >>> FRAC_BITS;
	assign speed_new = (sum > 0) ? ((s_shift > 64'sd65535) ? 16'hFFFF : s_shift[15:0]) : 16'd0;

	// sequencer: next state and unit requests
	always_comb begin
		state_d   = state_q;
		alu_req   = '0;
		load_rsp  = 1'b0;
		req.ready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (cmd_t'(req.cmd) == CMD_PLAN)
						state_d = ST_FIT;
					else if (idx_bad)
						state_d = ST_DONE;
					else if (idx_last)
						state_d = ST_U2;
					else
						state_d = ST_UDIV;
				end
			end
			ST_FIT: begin
				alu_req = '{start: 1'b1, op: ALU_DIV, a: q_num, b: ALU_DW'(plan_dur_q)};
				state_d = ST_FIT_WAIT;
			end
			ST_FIT_WAIT: begin
				if (alu_rsp.done) begin
					if (loop_q)
						state_d = ST_PEAK;
					else if (tune_q)
						state_d = ST_CHECK;
					else
						state_d = ST_CNT;
				end
			end
			ST_PEAK: begin
				if (c3_q == '0) begin
					state_d = ST_TRIAL_END;
				end else begin
					alu_req = '{start: 1'b1, op: ALU_MUL, a: ALU_NW'(c2_mag),
						b: ALU_DW'(c2_mag)};
					state_d = ST_SQ_WAIT;
				end
			end
			ST_SQ_WAIT: begin
				if (alu_rsp.done) begin
					alu_req = '{start: 1'b1, op: ALU_DIV, a: alu_rsp.result[ALU_NW-1:0],
						b: {c3_mag, 2'b00}};
					state_d = ST_PDIV_WAIT;
				end
			end
			ST_PDIV_WAIT: begin
				if (alu_rsp.done)
					state_d = ST_TRIAL_END;
			end
			ST_TRIAL_END: begin
				state_d = (trial_q == TW'(MAX_TRIALS)) ? ST_CNT : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = in_win ? ST_CNT : ST_FIT;
			end
			ST_CNT: begin
				alu_req = '{start: 1'b1, op: ALU_DIV, a: cnt_num, b: ALU_DW'(tick)};
				state_d = ST_CNT_WAIT;
			end
			ST_CNT_WAIT: begin
				if (alu_rsp.done)
					state_d = ST_DONE;
			end
			ST_UDIV: begin
				alu_req = '{start: 1'b1, op: ALU_DIV, a: u_num, b: ALU_DW'(plan_dur_q)};
				state_d = ST_UDIV_WAIT;
			end
			ST_UDIV_WAIT: begin
				if (alu_rsp.done)
					state_d = ST_U2;
			end
			ST_U2: begin
				alu_req = '{start: 1'b1, op: ALU_MUL, a: ALU_NW'(u_q), b: ALU_DW'(u_q)};
				state_d = ST_U2_WAIT;
			end
			ST_U2_WAIT: begin
				if (alu_rsp.done) begin
					alu_req = '{start: 1'b1, op: ALU_MUL, a: ALU_NW'(c2_mag), b: ALU_DW'(u_q)};
					state_d = ST_T2_WAIT;
				end
			end
			ST_T2_WAIT: begin
				if (alu_rsp.done) begin
					alu_req = '{start: 1'b1, op: ALU_MUL, a: ALU_NW'(c3_mag), b: ALU_DW'(u2_q)};
					state_d = ST_T3_WAIT;
				end
			end
			ST_T3_WAIT: begin
				if (alu_rsp.done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and planned state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plan_dur_q  <= RST_INITIAL_DURATION;
			v0_q        <= '0;
			c2_q        <= '0;
			c3_q        <= '0;
			count_q     <= '0;
			loop_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && cmd_t'(req.cmd) == CMD_PLAN) begin
						plan_dur_q <= init_dur;
						loop_q     <= 1'b0;
					end
				end
				ST_FIT_WAIT: begin
					if (alu_rsp.done) begin
						v0_q <= regs.start_speed;
						c2_q <= sat_coef(c2_wide);
						c3_q <= sat_coef(c3_wide);
						if (tune_q)
							loop_q <= 1'b1;
					end
				end
				ST_CHECK: begin
					if (!in_win)
						plan_dur_q <= dur_adj;
				end
				ST_CNT_WAIT: begin
					if (alu_rsp.done)
						count_q <= count_new;
				end
				default: ;
			endcase
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					tune_q  <= req.tune_duration;
					idx_q   <= req.sample_index;
					spd_q   <= '0;
					last_q  <= (cmd_t'(req.cmd) == CMD_SAMPLE) && !idx_bad && idx_last;
					bad_q   <= (cmd_t'(req.cmd) == CMD_SAMPLE) && idx_bad;
					peak_q  <= '0;
					trial_q <= '0;
					u_q     <= U_ONE;
				end
			end
			ST_PEAK: begin
				if (c3_q == '0)
					peak_q <= c1;
			end
			ST_PDIV_WAIT: begin
				if (alu_rsp.done)
					peak_q <= peak_new;
			end
			ST_TRIAL_END: begin
				if (trial_q != TW'(MAX_TRIALS))
					trial_q <= trial_q + 1'b1;
			end
			ST_UDIV_WAIT: begin
				if (alu_rsp.done)
					u_q <= u_new;
			end
			ST_U2_WAIT: begin
				if (alu_rsp.done)
					u2_q <= u2_new;
			end
			ST_T2_WAIT: begin
				if (alu_rsp.done)
					t2_q <= t2_new;
			end
			ST_T3_WAIT: begin
				if (alu_rsp.done)
					spd_q <= speed_new;
			end
			default: ;
		endcase
		if (load_rsp) begin
			rsp_speed_q <= spd_q;
			rsp_count_q <= count_q;
			rsp_dur_q   <= plan_dur_q;
			rsp_last_q  <= last_q;
			rsp_bad_q   <= bad_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.speed            = rsp_speed_q;
	assign rsp.sample_count     = rsp_count_q;
	assign rsp.planned_duration = rsp_dur_q;
	assign rsp.is_last          = rsp_last_q;
	assign rsp.index_bad        = rsp_bad_q;

endmodule

// ===== src/cvpg_checker.sv =====
`include "assert_macros.svh"

module cvpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] speed,
	input logic [15:0] planned_duration,
	input logic        is_last,
	input logic        index_bad
);

	// a stalled response holds
	`CVPG_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(speed))
	// one request in flight: busy right after taking one
	`CVPG_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	// a flagged index carries no speed and is never the last sample
	`CVPG_ASSERT_IMP(a_bad_clean, clk, arst_n, rsp_valid && index_bad, speed == 16'd0 && !is_last)
	// duration never collapses to zero
	`CVPG_ASSERT_IMP(a_dur_nonzero, clk, arst_n, rsp_valid, planned_duration != 16'd0)

endmodule

bind cubic_velocity_profile_generator cvpg_checker u_cvpg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.speed            (rsp.speed),
	.planned_duration (rsp.planned_duration),
	.is_last          (rsp.is_last),
	.index_bad        (rsp.index_bad)
);
